/* rtl/core/bdh_pkg.sv */
// ----------------------------------------------------------------------------
// Button debouncer package
// Shared types, register indexes and helpers for the debouncer with hold
// detection.
// ----------------------------------------------------------------------------
`default_nettype none

package bdh_pkg;

  // Widths of the fields and configuration registers.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsCfgW = 16;
  localparam int unsigned StateW = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_DEBOUNCE_MS  = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_HOLD_MS      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic              RST_ACTIVE_LEVEL = 1'b0;
  localparam logic [MsCfgW-1:0] RST_DEBOUNCE_MS  = 16'd50;
  localparam logic [MsCfgW-1:0] RST_HOLD_MS      = 16'd1000;

  // Reported button state codes.
  localparam logic [StateW-1:0] CODE_RELEASED = 2'd0;
  localparam logic [StateW-1:0] CODE_PRESS    = 2'd1;
  localparam logic [StateW-1:0] CODE_PRESSED  = 2'd2;
  localparam logic [StateW-1:0] CODE_HOLDING  = 2'd3;

  // Button state machine, one-hot.
  typedef enum logic [3:0] {
    ST_RELEASED = 4'b0001,
    ST_PRESS    = 4'b0010,
    ST_PRESSED  = 4'b0100,
    ST_HOLDING  = 4'b1000
  } bdh_state_t;

  // One result word.
  typedef struct packed {
    logic              click_event;
    logic              up_event;
    logic              hold_event;
    logic              down_event;
    logic [StateW-1:0] button_state;
  } bdh_result_t;

  // Maps the one-hot state onto the reported code.
  function automatic logic [StateW-1:0] state_code(input bdh_state_t st);
    logic [StateW-1:0] code;
    unique case (st)
      ST_RELEASED: code = CODE_RELEASED;
      ST_PRESS:    code = CODE_PRESS;
      ST_PRESSED:  code = CODE_PRESSED;
      ST_HOLDING:  code = CODE_HOLDING;
      default:     code = CODE_RELEASED;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bdh_step.sv */
// ----------------------------------------------------------------------------
// Button debouncer step logic
// Works out the next state, the press time stamp and the event flags for one
// pin sample, following the cascaded released/press/pressed/holding order.
// ----------------------------------------------------------------------------
`default_nettype none

module bdh_step import bdh_pkg::*; (
  input  wire bdh_state_t               state,
  input  wire logic [TimeW-1:0]         stamp,
  input  wire logic                     active,
  input  wire logic [TimeW-1:0]         now_ms,
  input  wire logic [MsCfgW-1:0]        debounce_ms,
  input  wire logic [MsCfgW-1:0]        hold_ms,
  output bdh_state_t                    state_nxt,
  output logic [TimeW-1:0]              stamp_nxt,
  output bdh_result_t                   result
);

  // Elapsed time is measured from the (possibly just taken) stamp.
  logic [TimeW-1:0] stamp_base;
  logic [TimeW-1:0] elapsed;
  logic             debounce_done;
  logic             hold_done;

  assign stamp_base    = (active && (state == ST_RELEASED)) ? now_ms : stamp;
  assign elapsed       = now_ms - stamp_base;
  assign debounce_done = elapsed >= {{(TimeW-MsCfgW){1'b0}}, debounce_ms};
  // A zero hold time never fires: it is kept out of the compare.
  assign hold_done     = (hold_ms != '0) &&
                         (elapsed >= {{(TimeW-MsCfgW){1'b0}}, hold_ms});

  // Cascaded state update: a press may go through to pressed and holding
  // within the same sample.
  always_comb begin
    bdh_state_t st;
    logic       down, hold, up, click;
    st        = state;
    stamp_nxt = stamp;
    down      = 1'b0;
    hold      = 1'b0;
    up        = 1'b0;
    click     = 1'b0;
    if (active) begin
      if (st == ST_RELEASED) begin
        stamp_nxt = now_ms;
        st        = ST_PRESS;
      end
      if ((st == ST_PRESS) || (st == ST_PRESSED)) begin
        if ((st == ST_PRESS) && debounce_done) begin
          st   = ST_PRESSED;
          down = 1'b1;
        end
        if (hold_done) begin
          st   = ST_HOLDING;
          hold = 1'b1;
        end
      end
    end else begin
      if (st == ST_PRESSED) begin
        up    = 1'b1;
        click = 1'b1;
      end else if (st == ST_HOLDING) begin
        up = 1'b1;
      end
      st = ST_RELEASED;
    end
    state_nxt           = st;
    result.button_state = state_code(st);
    result.down_event   = down;
    result.hold_event   = hold;
    result.up_event     = up;
    result.click_event  = click;
  end

endmodule

`default_nettype wire

/* rtl/core/button_debounce_hold_fsm.sv */
// Path: the input word is registered in the input stage, and its result word
// is then registered onto out_tdata, where it waits until it is taken.
// Throughput: one sample per cycle unless out_tready holds results back;
// the state machine and the 32-bit elapsed time subtract and compares sit in
// one stage between input and result registers; the state updates per sample.
// Reset: synchronous, active low; state released, stamp zero, registers at
// active level 0, debounce 50 ms and hold 1000 ms.
// ----------------------------------------------------------------------------
// Button debouncer with hold detection
// Streams pin samples with millisecond times in and state plus event flags
// out, one result word per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_hold_fsm import bdh_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input samples
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [InDataW-1:0]   in_tdata,   // [0] pin_level, [32:1] now_ms
  // Result words
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OutDataW-1:0]       out_tdata,  // [1:0] button_state,
                                                // [2] down_event, [3] hold_event,
                                                // [4] up_event, [5] click_event
  // Configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CfgAddrW-1:0]  cfg_addr,
  input  wire logic [CfgDataW-1:0]  cfg_wdata
);

  // Configuration registers.
  logic              active_level_r;
  logic [MsCfgW-1:0] debounce_ms_r;
  logic [MsCfgW-1:0] hold_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r <= RST_ACTIVE_LEVEL;
      debounce_ms_r  <= RST_DEBOUNCE_MS;
      hold_ms_r      <= RST_HOLD_MS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ACTIVE_LEVEL: active_level_r <= cfg_wdata[0];
        REG_DEBOUNCE_MS:  debounce_ms_r  <= cfg_wdata[MsCfgW-1:0];
        REG_HOLD_MS:      hold_ms_r      <= cfg_wdata[MsCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic             in_vld_r;
  logic             pin_r;
  logic [TimeW-1:0] now_r;
  logic             s1_adv;
  logic             out_vld_r;
  bdh_result_t      out_res_r;

  assign s1_adv    = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pin_r <= in_tdata[0];
      now_r <= in_tdata[TimeW:1];
    end
  end

  // Button state and the time of the last press.
  bdh_state_t       state_r, state_nxt;
  logic [TimeW-1:0] stamp_r, stamp_nxt;
  bdh_result_t      res_nxt;

  bdh_step u_step (
    .state       (state_r),
    .stamp       (stamp_r),
    .active      (pin_r == active_level_r),
    .now_ms      (now_r),
    .debounce_ms (debounce_ms_r),
    .hold_ms     (hold_ms_r),
    .state_nxt   (state_nxt),
    .stamp_nxt   (stamp_nxt),
    .result      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RELEASED;
      stamp_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutDataW-$bits(bdh_result_t)){1'b0}}, out_res_r};

  // A click is always a release as well.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.click_event |-> out_res_r.up_event)
    else $error("click without up");

  // A release always leaves the button released.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.up_event |-> out_res_r.button_state == CODE_RELEASED)
    else $error("up event with state not released");

  // A hold always leaves the button holding.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.hold_event |-> out_res_r.button_state == CODE_HOLDING)
    else $error("hold event with state not holding");

  // A press without a hold leaves the button pressed.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.down_event && !out_res_r.hold_event
      |-> out_res_r.button_state == CODE_PRESSED)
    else $error("down event with state not pressed");

  // The stamp only changes when a sample finds the button released.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (state_r != ST_RELEASED) |=> $stable(stamp_r))
    else $error("stamp changed outside a new press");

endmodule

`default_nettype wire

/* verif/tb_button_debounce_hold_fsm.sv */
// ----------------------------------------------------------------------------
// Testbench for the button debouncer with hold detection
// Streams pin samples with millisecond times into the block and checks each
// result word against a local model of the four-state press machine. The
// model is updated as each input word is accepted. Configuration is changed
// between phases once the block has drained. Both stream sides idle at
// random, and one phase holds the result side off long enough to stall the
// input side.
// ----------------------------------------------------------------------------
module tb_button_debounce_hold_fsm import bdh_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES    = 200_000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned LONG_STALL      = 300;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 120;

  // Spare register index; writes to it must leave the block untouched.
  localparam logic [CfgAddrW-1:0] REG_SPARE = 2'd3;

  // Result-side stall patterns.
  localparam int RX_FREE     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // [0] pin_level, [32:1] now_ms, rest zero
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // [1:0] button_state, [2] down_event,
                                   // [3] hold_event, [4] up_event,
                                   // [5] click_event, rest zero
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  // Tracks the button as the block should see it and holds the words it owes.
  class button_scoreboard;
    logic              act_level;
    logic [MsCfgW-1:0] debounce;
    logic [MsCfgW-1:0] hold;
    logic [StateW-1:0] fsm;
    logic [TimeW-1:0]  stamp;
    bdh_result_t       due_reports[$];
    int unsigned       faults;

    function new();
      act_level = RST_ACTIVE_LEVEL;
      debounce  = RST_DEBOUNCE_MS;
      hold      = RST_HOLD_MS;
      fsm       = CODE_RELEASED;
      stamp     = '0;
      faults    = 0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_ACTIVE_LEVEL: act_level = data[0];
        REG_DEBOUNCE_MS:  debounce  = data[MsCfgW-1:0];
        REG_HOLD_MS:      hold      = data[MsCfgW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    // One sample through the machine. The press-pending and hold checks run
    // in cascade, so a single sample may raise down and hold together.
    function void note_sample(logic pin, logic [TimeW-1:0] now);
      bdh_result_t       r;
      logic [TimeW-1:0]  elapsed;
      logic [StateW-1:0] st;
      r  = '0;
      st = fsm;
      if (pin == act_level) begin
        if (st == CODE_RELEASED) begin
          stamp = now;
          st    = CODE_PRESS;
        end
        if (st == CODE_PRESS || st == CODE_PRESSED) begin
          elapsed = now - stamp;
          if (st == CODE_PRESS && elapsed >= {16'd0, debounce}) begin
            st           = CODE_PRESSED;
            r.down_event = 1'b1;
          end
          // A zero hold time wraps the threshold to the maximum: never fires.
          if (elapsed > ({16'd0, hold} - 32'd1)) begin
            st           = CODE_HOLDING;
            r.hold_event = 1'b1;
          end
        end
      end else begin
        if (st == CODE_PRESSED) begin
          r.up_event    = 1'b1;
          r.click_event = 1'b1;
        end else if (st == CODE_HOLDING) begin
          r.up_event = 1'b1;
        end
        st = CODE_RELEASED;
      end
      fsm            = st;
      r.button_state = st;
      due_reports.push_back(r);
    endfunction

    function void check_word(bdh_result_t got);
      bdh_result_t exp_r;
      if (due_reports.size() == 0) begin
        $error("result word 0x%02h arrived with nothing outstanding", got);
        faults++;
        return;
      end
      exp_r = due_reports.pop_front();
      if (got.button_state != exp_r.button_state) begin
        $error("button_state: expected %0d, got %0d", exp_r.button_state, got.button_state);
        faults++;
      end
      if (got.down_event != exp_r.down_event) begin
        $error("down_event: expected %0d, got %0d", exp_r.down_event, got.down_event);
        faults++;
      end
      if (got.hold_event != exp_r.hold_event) begin
        $error("hold_event: expected %0d, got %0d", exp_r.hold_event, got.hold_event);
        faults++;
      end
      if (got.up_event != exp_r.up_event) begin
        $error("up_event: expected %0d, got %0d", exp_r.up_event, got.up_event);
        faults++;
      end
      if (got.click_event != exp_r.click_event) begin
        $error("click_event: expected %0d, got %0d", exp_r.click_event, got.click_event);
        faults++;
      end
    endfunction
  endclass

  button_scoreboard sb;

  // Sender pacing and the current sample time of a random phase.
  int unsigned      burst_left = 0;
  bit               steady     = 1'b0;
  logic [TimeW-1:0] cur_ms;
  int unsigned      step_cap;
  int unsigned      phase_sent;

  // Long hold-off requests from the stimulus to the receiver process.
  int unsigned stall_asked  = 0;
  int unsigned stall_served = 0;
  int unsigned hold_left    = 0;
  int          rx_mode      = RX_FREE;
  int unsigned rx_left      = 0;
  int unsigned rx_count     = 0;
  int unsigned cycles       = 0;

  button_debounce_hold_fsm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Both stream sides are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_sample(in_tdata[0], in_tdata[32:1]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_word(bdh_result_t'(out_tdata[5:0]));
      end
    end
  end

  // Receiver: changes between free running, random and periodic stalls, and
  // serves a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (stall_asked != stall_served && hold_left == 0) begin
      hold_left = LONG_STALL;
      stall_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_PERIODIC);
        rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      rx_count++;
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default:   out_tready <= ((rx_count % 5) < 2);
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one word and returns at the falling edge after it is taken; valid
  // is left high so that the next word can follow without a gap.
  task automatic push_sample(input logic pin, input logic [TimeW-1:0] now);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 5);
      end
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW-TimeW-1){1'b0}}, now, pin};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed word has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Writes every register, plus the spare index, once the block is idle.
  task automatic program_button(input logic act, input logic [MsCfgW-1:0] deb,
                                input logic [MsCfgW-1:0] hold);
    wait_drained();
    put_reg(REG_ACTIVE_LEVEL, {{(CfgDataW-1){1'b0}}, act});
    put_reg(REG_SPARE, CfgDataW'($urandom()));
    put_reg(REG_DEBOUNCE_MS, deb);
    put_reg(REG_HOLD_MS, hold);
    cfg_we <= 1'b0;
  endtask

  // Advances the time, now and then jumping anywhere or stepping backwards.
  task automatic emit(input logic pin);
    int unsigned pick;
    pick = $urandom_range(0, 49);
    if (pick == 0) begin
      cur_ms = $urandom();
    end else if (pick == 1) begin
      cur_ms = cur_ms - $urandom_range(1, step_cap);
    end else begin
      cur_ms = cur_ms + $urandom_range(0, step_cap);
    end
    push_sample(pin, cur_ms);
    phase_sent++;
  endtask

  // One random phase: a setting, then press cycles with bounce and noise.
  task automatic run_phase(input int unsigned p);
    logic              act;
    logic [MsCfgW-1:0] deb;
    logic [MsCfgW-1:0] hold;
    int unsigned       n;
    act = logic'((p + p / 6) % 2);
    case (p % 6)
      0: begin
        deb  = '0;
        hold = MsCfgW'($urandom_range(1, 40));
      end
      1: begin
        deb  = 16'hFFFF;
        hold = 16'hFFFF;
      end
      2: begin
        deb  = MsCfgW'($urandom_range(0, 30));
        hold = '0;
      end
      3: begin
        deb  = MsCfgW'($urandom_range(5, 40));
        hold = 16'd1;
      end
      4: begin
        // Hold often shorter than debounce: holding can be reached with no down.
        deb  = MsCfgW'($urandom_range(10, 60));
        hold = MsCfgW'($urandom_range(1, 20));
      end
      default: begin
        deb  = MsCfgW'($urandom_range(0, 30));
        hold = MsCfgW'($urandom_range(20, 120));
      end
    endcase
    program_button(act, deb, hold);
    step_cap   = ((deb > hold) ? deb : hold) / 8 + 2;
    cur_ms     = (p == 3) ? 32'hFFFF_F000 : $urandom();
    phase_sent = 0;
    steady     = (p % 4 == 1) || (p == 5);
    burst_left = 0;
    if (p == 5) begin
      stall_asked++;
    end
    while (phase_sent < ITEMS_PER_PHASE) begin
      n = $urandom_range(1, 4);
      repeat (n) emit(~act);
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) emit(logic'($urandom_range(0, 1)));
      end
      n = $urandom_range(1, 25);
      repeat (n) emit(($urandom_range(0, 9) == 0) ? ~act : act);
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: active low, debounce 50, hold 1000.
    push_sample(1'b1, 32'd0);
    push_sample(1'b0, 32'd100);
    push_sample(1'b0, 32'd149);
    push_sample(1'b0, 32'd150);            // debounce met: down
    push_sample(1'b1, 32'd160);            // short click
    push_sample(1'b0, 32'd200);
    push_sample(1'b0, 32'd1200);           // down and hold in one sample
    push_sample(1'b0, 32'd1300);
    push_sample(1'b1, 32'd1400);           // release from holding: up only
    push_sample(1'b0, 32'd2000);
    push_sample(1'b1, 32'd2010);           // bounce while pending: no event
    push_sample(1'b0, 32'hFFFF_FFF0);
    push_sample(1'b0, 32'h0000_0040);      // elapsed across the time wrap
    push_sample(1'b1, 32'hFFFF_FFFF);
    push_sample(1'b0, 32'd1000);
    push_sample(1'b0, 32'd900);            // time going backwards
    push_sample(1'b1, 32'd0);

    // Zero debounce and zero hold, active high.
    program_button(1'b1, 16'd0, 16'd0);
    push_sample(1'b1, 32'd500);
    push_sample(1'b1, 32'd499);            // largest elapsed, still no hold
    push_sample(1'b0, 32'd600);

    // Hold reached straight from press pending.
    program_button(1'b1, 16'hFFFF, 16'd10);
    push_sample(1'b1, 32'd0);
    push_sample(1'b1, 32'd11);
    push_sample(1'b0, 32'd12);

    // Largest debounce and hold.
    program_button(1'b0, 16'hFFFF, 16'hFFFF);
    push_sample(1'b0, 32'd7);
    push_sample(1'b0, 32'd7 + 32'd65535);
    push_sample(1'b1, 32'd70000);

    for (int unsigned p = 0; p < PHASES; p++) begin
      run_phase(p);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bdh_pkg.sv
rtl/core/bdh_step.sv
rtl/core/button_debounce_hold_fsm.sv
verif/tb_button_debounce_hold_fsm.sv
